// ===== design/frx_pkg.sv =====
// shared constants and types of the focuser reply frame receiver
package frx_pkg;

	localparam logic [7:0] START_BYTE = 8'h46;
	localparam logic [7:0] LETTER_G   = 8'h47;
	localparam logic [7:0] LETTER_D   = 8'h44;
	localparam logic [7:0] SWITCH_ON  = 8'h32;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] DIGIT_NINE = 8'h39;

	localparam logic [3:0] POS_HUNT   = 4'd0;
	localparam logic [3:0] POS_LETTER = 4'd1;
	localparam logic [3:0] POS_SWITCH = 4'd4;
	localparam logic [3:0] POS_CHECK  = 4'd8;

	localparam logic [15:0] SKIP_MAX = 16'hFFFF;

	typedef struct packed {
		logic [7:0]  command_letter;
		logic [47:0] payload_raw;
		logic [19:0] decimal_value;
		logic [3:0]  switch_mask;
		logic        checksum_ok;
		logic        command_match;
		logic [15:0] skipped_bytes;
	} frx_result_t;

	typedef struct packed {
		logic frame_last;
	} frx_status_t;

endpackage

// ===== design/frx_frame_core.sv =====
// frame state, running sum, digit accumulation and result forming
module frx_frame_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         rx_byte,
	input  logic               cfg_write,
	input  logic [7:0]         cfg_data,
	output frx_pkg::frx_result_t result,
	output frx_pkg::frx_status_t status
);
	import frx_pkg::*;

	logic [3:0]  pos_q;
	logic [7:0]  sum_q;
	logic [7:0]  letter_q;
	logic [47:0] payload_q;
	logic [19:0] acc_q;
	logic        ended_q;
	logic [3:0]  switch_q;
	logic [15:0] skip_q;
	logic [7:0]  expected_q;

	logic        hunting;
	logic        is_digit;
	logic [19:0] acc_next;

	assign hunting  = (pos_q == POS_HUNT) || (pos_q > POS_CHECK);
	assign is_digit = (rx_byte >= DIGIT_ZERO) && (rx_byte <= DIGIT_NINE);
	assign acc_next = {acc_q[16:0], 3'b000} + {acc_q[18:0], 1'b0}
		+ {16'd0, rx_byte[3:0]};

	assign status.frame_last = (pos_q == POS_CHECK);

	assign result.command_letter = letter_q;
	assign result.payload_raw    = payload_q;
	assign result.decimal_value  = acc_q;
	assign result.switch_mask    = switch_q;
	assign result.checksum_ok    = (rx_byte == sum_q);
	assign result.command_match  = (letter_q == expected_q)
		|| ((expected_q == LETTER_G) && (letter_q == LETTER_D));
	assign result.skipped_bytes  = skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= LETTER_G;
		end else if (cfg_write) begin
			expected_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_HUNT;
			sum_q     <= '0;
			letter_q  <= '0;
			payload_q <= '0;
			acc_q     <= '0;
			ended_q   <= 1'b0;
			switch_q  <= '0;
			skip_q    <= '0;
		end else if (accept) begin
			if (hunting || (pos_q == POS_CHECK)) begin
				letter_q  <= '0;
				payload_q <= '0;
				acc_q     <= '0;
				ended_q   <= 1'b0;
				switch_q  <= '0;
			end
			if (hunting) begin
				if (rx_byte == START_BYTE) begin
					pos_q <= POS_LETTER;
					sum_q <= rx_byte;
				end else begin
					pos_q <= POS_HUNT;
					sum_q <= '0;
					if (skip_q != SKIP_MAX) begin
						skip_q <= skip_q + 16'd1;
					end
				end
			end else if (pos_q == POS_CHECK) begin
				pos_q  <= POS_HUNT;
				sum_q  <= '0;
				skip_q <= '0;
			end else begin
				sum_q <= sum_q + rx_byte;
				pos_q <= pos_q + 4'd1;
				if (pos_q == POS_LETTER) begin
					letter_q <= rx_byte;
				end else begin
					payload_q <= {payload_q[39:0], rx_byte};
					if (!ended_q) begin
						if (is_digit) begin
							acc_q <= acc_next;
						end else begin
							ended_q <= 1'b1;
						end
					end
					if ((pos_q >= POS_SWITCH) && (rx_byte == SWITCH_ON)) begin
						switch_q[pos_q[1:0]] <= 1'b1;
					end
				end
			end
		end
	end

endmodule

// ===== design/frx_out_reg.sv =====
// result register between the frame logic and the output channel
module frx_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  frx_pkg::frx_result_t result_in,
	input  logic                 out_stall,
	output logic                 out_valid,
	output frx_pkg::frx_result_t result_out
);
	import frx_pkg::*;

	logic        valid_q;
	frx_result_t data_q;

	assign out_valid  = valid_q;
	assign result_out = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result_in;
		end
	end

endmodule

// ===== design/focuser_reply_frame_receiver.sv =====
// top level of the focuser reply frame receiver
// result: a result word appears in the cycle after the ninth frame byte is accepted
// throughput: one byte word per cycle; the last frame byte stalls only while
//   the previous result word is still held by a stalled output
// reset: asynchronous active low, clears frame state, skip count and output
//   valid, expected command returns to 'G'
module focuser_reply_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_write,
	input  logic [7:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  command_letter,
	output logic [47:0] payload_raw,
	output logic [19:0] decimal_value,
	output logic [3:0]  switch_mask,
	output logic        checksum_ok,
	output logic        command_match,
	output logic [15:0] skipped_bytes
);
	import frx_pkg::*;

	frx_result_t result;
	frx_result_t result_out;
	frx_status_t status;
	logic        accept;

	assign in_stall = status.frame_last && out_valid && out_stall;
	assign accept   = in_valid && !in_stall;

	frx_frame_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.result    (result),
		.status    (status)
	);

	frx_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept && status.frame_last),
		.result_in  (result),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.result_out (result_out)
	);

	assign command_letter = result_out.command_letter;
	assign payload_raw    = result_out.payload_raw;
	assign decimal_value  = result_out.decimal_value;
	assign switch_mask    = result_out.switch_mask;
	assign checksum_ok    = result_out.checksum_ok;
	assign command_match  = result_out.command_match;
	assign skipped_bytes  = result_out.skipped_bytes;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && status.frame_last))
		else $error("input stalled without a held result");

	a_rise_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(accept && status.frame_last))
		else $error("result appeared without a completed frame");

	a_held_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

endmodule
